FILE: rtl/expression_token_lexer_defines.svh
// Assertion macros for the expression token lexer.
// Included by the RTL modules that carry concurrent checks.
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH

// Check sampled on clock, off while reset is high.
`define ETL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check sampled on clock, also during reset.
`define ETL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/etl_pkg.sv
// Types, codes and helper functions for the expression token lexer.
// No dependencies; imported by every lexer module.
package etl_pkg;

   localparam int unsigned MAX_TEXT_LENGTH = 65536;
   localparam logic [15:0] POS_CAP =
      16'((MAX_TEXT_LENGTH - 1 > 65535) ? 65535 : MAX_TEXT_LENGTH - 1);

   localparam int NUM_SLOT = 3;

   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_INT   = 2'd1;
   localparam logic [1:0] CLS_IDENT = 2'd2;
   localparam logic [1:0] CLS_OP    = 2'd3;

   localparam logic [1:0] KW_NONE = 2'd0;
   localparam logic [1:0] KW_IF   = 2'd1;
   localparam logic [1:0] KW_THEN = 2'd2;
   localparam logic [1:0] KW_ELSE = 2'd3;

   localparam logic [4:0] KIND_INT     = 5'd0;
   localparam logic [4:0] KIND_IDENT   = 5'd1;
   localparam logic [4:0] KIND_OP_LOW  = 5'd5;
   localparam logic [4:0] KIND_CMP_LOW = 5'd15;
   localparam logic [4:0] KIND_LPAREN  = 5'd13;
   localparam logic [4:0] KIND_RPAREN  = 5'd14;
   localparam logic [4:0] KIND_UNKNOWN = 5'd23;
   localparam logic [4:0] KIND_END     = 5'd24;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                 cnt;
      rsp_type [NUM_SLOT-1:0]     tok;
   } grp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   // Operator byte to index among + - * / > < = !
   function automatic logic [3:0] op_lookup(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         8'h2B:   r = {1'b1, 3'd0};
         8'h2D:   r = {1'b1, 3'd1};
         8'h2A:   r = {1'b1, 3'd2};
         8'h2F:   r = {1'b1, 3'd3};
         8'h3E:   r = {1'b1, 3'd4};
         8'h3C:   r = {1'b1, 3'd5};
         8'h3D:   r = {1'b1, 3'd6};
         8'h21:   r = {1'b1, 3'd7};
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] single_kind(input logic [2:0] idx);
      logic [4:0] r;
      if (!idx[2]) begin
         r = KIND_OP_LOW + {2'b0, idx[1:0], 1'b0};
      end else begin
         r = KIND_CMP_LOW + {2'b0, idx[1:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [15:0] kw_len(input logic [1:0] k);
      logic [15:0] r;
      case (k)
         KW_IF:   r = 16'd2;
         KW_THEN: r = 16'd4;
         KW_ELSE: r = 16'd4;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [1:0] i);
      logic [7:0] r;
      case ({k, i})
         {KW_IF, 2'd0}:   r = 8'h69;
         {KW_IF, 2'd1}:   r = 8'h66;
         {KW_THEN, 2'd0}: r = 8'h74;
         {KW_THEN, 2'd1}: r = 8'h68;
         {KW_THEN, 2'd2}: r = 8'h65;
         {KW_THEN, 2'd3}: r = 8'h6E;
         {KW_ELSE, 2'd0}: r = 8'h65;
         {KW_ELSE, 2'd1}: r = 8'h6C;
         {KW_ELSE, 2'd2}: r = 8'h73;
         {KW_ELSE, 2'd3}: r = 8'h65;
         default:         r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] flush_kind(input logic [1:0] cls, input logic [2:0] op,
                                             input logic [1:0] kp, input logic [15:0] len);
      logic [4:0] r;
      case (cls)
         CLS_INT:   r = KIND_INT;
         CLS_IDENT: r = ((kp != KW_NONE) && (len == kw_len(kp))) ? 5'd1 + {3'd0, kp}
                                                                  : KIND_IDENT;
         CLS_OP:    r = single_kind(op);
         default:   r = KIND_INT;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/etl_scan.sv
// Lexer state and per-byte token logic: one byte in, up to three tokens out.
// Depends on etl_pkg.
module etl_scan import etl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  req_type beat,
   output grp_type grp
);

   logic [1:0]  cls_ff, cls_in;
   logic [2:0]  op_ff, op_in;
   logic [1:0]  kp_ff, kp_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic        disc_ff, disc_in;

   always_comb begin
      rsp_type    t0, t1, t2, t3;
      logic       v0, v1, v2;
      logic       used;
      logic [7:0] c;
      logic [3:0] opl;
      logic [1:0] n;

      t0 = '0;
      t1 = '0;
      t2 = '0;
      t3 = '0;
      v0 = 1'b0;
      v1 = 1'b0;
      v2 = 1'b0;
      used = 1'b0;
      c = beat.char_code;
      opl = op_lookup(c);
      cls_in = cls_ff;
      op_in = op_ff;
      kp_in = kp_ff;
      start_in = start_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      disc_in = disc_ff;
      grp = '0;

      if (!disc_ff) begin
         case (cls_ff)
            CLS_OP: begin
               v0 = 1'b1;
               t0.start_offset = start_ff;
               if (c == CH_EQ) begin
                  t0.token_kind = single_kind(op_ff) + 5'd1;
                  t0.token_length = 16'd2;
                  used = 1'b1;
               end else begin
                  t0.token_kind = single_kind(op_ff);
                  t0.token_length = len_ff;
               end
            end
            CLS_INT: begin
               if (is_digit(c)) begin
                  used = 1'b1;
               end else begin
                  v0 = 1'b1;
                  t0.token_kind = KIND_INT;
                  t0.start_offset = start_ff;
                  t0.token_length = len_ff;
               end
            end
            CLS_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                  used = 1'b1;
                  if (kp_ff != KW_NONE && !(len_ff < kw_len(kp_ff) &&
                                            kw_char(kp_ff, len_ff[1:0]) == c)) begin
                     kp_in = KW_NONE;
                  end
               end else begin
                  v0 = 1'b1;
                  t0.token_kind = flush_kind(cls_ff, op_ff, kp_ff, len_ff);
                  t0.start_offset = start_ff;
                  t0.token_length = len_ff;
               end
            end
            default: ;
         endcase

         if (used && cls_ff != CLS_OP) begin
            if (len_ff < 16'hFFFF) begin
               len_in = len_ff + 16'd1;
            end
         end else begin
            cls_in = CLS_NONE;
            op_in = 3'd0;
            kp_in = KW_NONE;
            start_in = 16'd0;
            len_in = 16'd0;
         end

         if (!used) begin
            if (c == CH_NUL) begin
               disc_in = 1'b1;
            end else if (is_space(c)) begin
               cls_in = CLS_NONE;
            end else if (is_digit(c)) begin
               cls_in = CLS_INT;
               start_in = pos_ff;
               len_in = 16'd1;
            end else if (is_alpha(c) || c == CH_UNDER) begin
               cls_in = CLS_IDENT;
               start_in = pos_ff;
               len_in = 16'd1;
               kp_in = (c == 8'h69) ? KW_IF : (c == 8'h74) ? KW_THEN :
                       (c == 8'h65) ? KW_ELSE : KW_NONE;
            end else if (opl[3]) begin
               cls_in = CLS_OP;
               op_in = opl[2:0];
               start_in = pos_ff;
               len_in = 16'd1;
            end else begin
               v1 = 1'b1;
               t1.start_offset = pos_ff;
               t1.token_length = 16'd1;
               t1.token_kind = (c == CH_LPAR) ? KIND_LPAREN :
                               (c == CH_RPAR) ? KIND_RPAREN : KIND_UNKNOWN;
            end
         end

         if (!disc_in && pos_ff < POS_CAP) begin
            pos_in = pos_ff + 16'd1;
         end
      end

      if (beat.end_of_text) begin
         v2 = (cls_in != CLS_NONE);
         t2.token_kind = flush_kind(cls_in, op_in, kp_in, len_in);
         t2.start_offset = start_in;
         t2.token_length = len_in;
         t3.token_kind = KIND_END;
         t3.start_offset = pos_in;
         t3.token_length = 16'd0;
         cls_in = CLS_NONE;
         op_in = 3'd0;
         kp_in = KW_NONE;
         start_in = 16'd0;
         len_in = 16'd0;
         pos_in = 16'd0;
         disc_in = 1'b0;
      end

      // pack valid tokens into consecutive slots
      n = 2'd0;
      if (v0) begin
         grp.tok[n] = t0;
         n = n + 2'd1;
      end
      if (v1) begin
         grp.tok[n] = t1;
         n = n + 2'd1;
      end
      if (v2) begin
         grp.tok[n] = t2;
         n = n + 2'd1;
      end
      if (beat.end_of_text) begin
         grp.tok[n] = t3;
         n = n + 2'd1;
      end
      for (int i = 0; i < NUM_SLOT; i++) begin
         grp.tok[i].last_of_run = (2'(i) == n - 2'd1);
      end
      grp.cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff <= CLS_NONE;
         op_ff <= 3'd0;
         kp_ff <= KW_NONE;
         start_ff <= 16'd0;
         len_ff <= 16'd0;
         pos_ff <= 16'd0;
         disc_ff <= 1'b0;
      end else if (go) begin
         cls_ff <= cls_in;
         op_ff <= op_in;
         kp_ff <= kp_in;
         start_ff <= start_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         disc_ff <= disc_in;
      end
   end

endmodule

FILE: rtl/etl_serial.sv
// Token group register: holds up to three tokens of one byte and hands them
// out one beat at a time. Depends on etl_pkg and the assertion macros.
`include "expression_token_lexer_defines.svh"

module etl_serial import etl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  grp_type grp,
   output logic    grp_free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                   valid_ff;
   logic [1:0]             cnt_ff;
   logic [1:0]             idx_ff;
   rsp_type [NUM_SLOT-1:0] tok_ff;
   logic                   at_last;

   assign at_last   = (idx_ff == cnt_ff - 2'd1);
   assign grp_free  = !valid_ff || (!rsp_stall && at_last);
   assign rsp_valid = valid_ff;
   assign rsp_data  = tok_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         cnt_ff <= grp.cnt;
         idx_ff <= 2'd0;
      end else if (valid_ff && !rsp_stall) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= grp.tok;
      end
   end

   `ETL_ASSERT(a_idx_in_group, valid_ff |-> (idx_ff < cnt_ff), "slot index past token count")
   `ETL_ASSERT(a_load_when_free, load |-> grp_free, "group overwritten before drained")
   `ETL_ASSERT(a_last_flag, valid_ff |-> (rsp_data.last_of_run == at_last), "last flag off")
   `ETL_ASSERT(a_stall_holds_slot, (valid_ff && rsp_stall) |=> (valid_ff && $stable(idx_ff)),
      "held beat moved")

endmodule

FILE: rtl/expression_token_lexer.sv
// Top level of the expression token lexer; depends on etl_pkg, etl_scan and etl_serial.
// A byte is held in the input register, then its tokens in the etl_serial group register.
// Throughput: one byte per cycle while each byte yields at most one token and rsp_stall is
// low; a byte with more tokens holds the input while the single-token port hands them out.
// Reset (synchronous, active high) empties both registers and returns the lexer to
// position zero with nothing pending.
module expression_token_lexer import etl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    grp_free;
   logic    advance;
   logic    accept;
   grp_type grp;

   assign advance   = in_valid_ff && grp_free;
   assign req_stall = in_valid_ff && !grp_free;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   etl_scan u_scan (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .beat  (in_data_ff),
      .grp   (grp)
   );

   etl_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && (grp.cnt != 2'd0)),
      .grp       (grp),
      .grp_free  (grp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/expression_token_lexer_tb.sv
`timescale 1ns / 1ps
// Testbench for expression_token_lexer: streams source text bytes with random idling
// and output backpressure, and checks each token beat against an in-bench lexer model.
// Depends on etl_pkg and the expression_token_lexer RTL.
module expression_token_lexer_tb import etl_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT  = 20000;
   localparam int unsigned RANDOM_BYTES = 250;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned TAIL_CYCLES  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type     text_bytes [$];
   rsp_type     tokens_due [$];
   int unsigned bytes_sent  = 0;
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   int unsigned step_count  = 0;

   string op_chars = "+-*/><=!";
   string id_words [9] = '{"if", "then", "else", "i", "the", "elsex", "iF", "th3n", "els"};

   // lexer model state
   logic [1:0]  pend_cls   = CLS_NONE;
   logic [2:0]  pend_op    = 3'd0;
   logic [1:0]  pend_kw    = KW_NONE;
   logic [15:0] pend_start = 16'd0;
   logic [15:0] pend_len   = 16'd0;
   logic [15:0] text_pos   = 16'd0;
   logic        discarding = 1'b0;

   expression_token_lexer i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic is_num(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic string kw_word(input logic [1:0] k);
      case (k)
         KW_IF:   return "if";
         KW_THEN: return "then";
         KW_ELSE: return "else";
         default: return "";
      endcase
   endfunction

   function automatic logic [4:0] op_kind(input logic [2:0] i);
      if (i < 3'd4) begin
         return KIND_OP_LOW + 5'(2 * i);
      end
      return KIND_CMP_LOW + 5'(2 * (i - 3'd4));
   endfunction

   function automatic void put_token(input logic [4:0] kind, input logic [15:0] start,
                                     input logic [15:0] len);
      rsp_type t;
      t.token_kind   = kind;
      t.start_offset = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      tokens_due.insert(tokens_due.size(), t);
      step_count++;
   endfunction

   function automatic void clear_pending();
      pend_cls   = CLS_NONE;
      pend_op    = 3'd0;
      pend_kw    = KW_NONE;
      pend_start = 16'd0;
      pend_len   = 16'd0;
   endfunction

   function automatic void release_pending();
      string      word;
      logic [4:0] kind;
      word = kw_word(pend_kw);
      if (pend_cls == CLS_INT) begin
         kind = KIND_INT;
      end else if (pend_cls == CLS_IDENT) begin
         kind = (pend_kw != KW_NONE && pend_len == word.len()) ? KIND_IDENT + 5'(pend_kw)
                                                                : KIND_IDENT;
      end else begin
         kind = op_kind(pend_op);
      end
      if (pend_cls != CLS_NONE) begin
         put_token(kind, pend_start, pend_len);
         clear_pending();
      end
   endfunction

   function automatic void lex_byte(input req_type r);
      logic [7:0] c;
      logic       taken;
      logic       op_hit;
      logic [2:0] op_at;
      string      word;
      int         i;
      c          = r.char_code;
      taken      = 1'b0;
      op_hit     = 1'b0;
      op_at      = 3'd0;
      step_count = 0;
      if (!discarding) begin
         if (pend_cls == CLS_OP) begin
            if (c == CH_EQ) begin
               put_token(op_kind(pend_op) + 5'd1, pend_start, 16'd2);
               clear_pending();
               taken = 1'b1;
            end else begin
               release_pending();
            end
         end else if (pend_cls == CLS_INT) begin
            if (is_num(c)) begin
               if (pend_len != 16'hFFFF) pend_len++;
               taken = 1'b1;
            end else begin
               release_pending();
            end
         end else if (pend_cls == CLS_IDENT) begin
            if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
               word = kw_word(pend_kw);
               if (pend_kw != KW_NONE && !(pend_len < word.len() && word[pend_len] == c)) begin
                  pend_kw = KW_NONE;
               end
               if (pend_len != 16'hFFFF) pend_len++;
               taken = 1'b1;
            end else begin
               release_pending();
            end
         end

         if (!taken) begin
            for (i = 0; i < 8; i++) begin
               if (op_chars[i] == c) begin
                  op_hit = 1'b1;
                  op_at  = 3'(i);
               end
            end
            if (c == CH_NUL) begin
               discarding = 1'b1;
            end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
               // whitespace
            end else if (is_num(c)) begin
               pend_cls   = CLS_INT;
               pend_start = text_pos;
               pend_len   = 16'd1;
            end else if (is_letter(c) || c == CH_UNDER) begin
               pend_cls   = CLS_IDENT;
               pend_start = text_pos;
               pend_len   = 16'd1;
               pend_kw    = (c == "i") ? KW_IF : (c == "t") ? KW_THEN :
                            (c == "e") ? KW_ELSE : KW_NONE;
            end else if (op_hit) begin
               pend_cls   = CLS_OP;
               pend_op    = op_at;
               pend_start = text_pos;
               pend_len   = 16'd1;
            end else if (c == CH_LPAR) begin
               put_token(KIND_LPAREN, text_pos, 16'd1);
            end else if (c == CH_RPAR) begin
               put_token(KIND_RPAREN, text_pos, 16'd1);
            end else begin
               put_token(KIND_UNKNOWN, text_pos, 16'd1);
            end
         end

         if (!discarding && text_pos < POS_CAP) text_pos++;
      end

      if (r.end_of_text) begin
         release_pending();
         put_token(KIND_END, text_pos, 16'd0);
         clear_pending();
         text_pos   = 16'd0;
         discarding = 1'b0;
      end

      if (step_count > 0) begin
         tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   function automatic void put_byte(input logic [7:0] c);
      req_type b;
      b.char_code   = c;
      b.end_of_text = 1'b0;
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function automatic void put_string(input string s);
      for (int k = 0; k < s.len(); k++) put_byte(s[k]);
   endfunction

   function automatic void close_text();
      text_bytes[text_bytes.size() - 1].end_of_text = 1'b1;
   endfunction

   function automatic logic [7:0] word_char(input bit lead);
      int unsigned r;
      r = $urandom_range(lead ? 52 : 62);
      if (r < 26) return 8'(8'h41 + r);
      if (r < 52) return 8'(8'h61 + r - 26);
      if (r == 52) return CH_UNDER;
      return 8'(8'h30 + r - 53);
   endfunction

   // no idling on either side in this window
   function automatic logic take_break();
      return !(bytes_sent >= 120 && bytes_sent < 400) && ($urandom_range(99) < 7);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) bytes_sent <= bytes_sent + 1;
         if (text_bytes.size() != 0 && !take_break()) begin
            req_valid <= 1'b1;
            req_data  <= text_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long hold-off so the lexer backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && bytes_sent >= 60) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= take_break();
      end
   end

   always @(posedge clock) begin : check_tokens
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected token beat: kind %0d start %0d len %0d last %0b",
                           rsp_data.token_kind, rsp_data.start_offset,
                           rsp_data.token_length, rsp_data.last_of_run);
               end
            end else begin
               want = tokens_due.pop_front();
               if (rsp_data.token_kind !== want.token_kind ||
                   rsp_data.start_offset !== want.start_offset ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("token mismatch: expected kind %0d start %0d len %0d last %0b",
                              want.token_kind, want.start_offset, want.token_length,
                              want.last_of_run);
                     $display("                got      kind %0d start %0d len %0d last %0b",
                              rsp_data.token_kind, rsp_data.start_offset,
                              rsp_data.token_length, rsp_data.last_of_run);
                  end
               end
            end
         end
         if (req_valid && !req_stall) lex_byte(req_data);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned directed_n;
      int unsigned pick;
      int unsigned r;
      string       punct;
      punct = "#.,;:@$%&~?[]{}^|";

      // keyword, parens, underscore ident, high unknown byte on the end mark
      put_string("if(_9)");
      put_byte(8'hFF);
      close_text();
      // compound operator, single operator flushed by the end mark
      put_string("then<=!");
      close_text();
      // unknown 0x80, zero byte flushes the integer, rest discarded
      put_string("else");
      put_byte(8'h80);
      put_string("7");
      put_byte(CH_NUL);
      put_string("z");
      close_text();
      put_byte(8'h20);
      close_text();
      directed_n = text_bytes.size();

      while (text_bytes.size() < directed_n + RANDOM_BYTES) begin
         repeat ($urandom_range(3, 12)) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
               repeat ($urandom_range(1, 6)) put_byte(8'(8'h30 + $urandom_range(9)));
            end else if (pick < 40) begin
               if ($urandom_range(1)) begin
                  put_string(id_words[$urandom_range(8)]);
               end else begin
                  put_byte(word_char(1'b1));
                  repeat ($urandom_range(7)) put_byte(word_char(1'b0));
               end
            end else if (pick < 60) begin
               put_byte(op_chars[$urandom_range(7)]);
               if ($urandom_range(1)) put_byte(CH_EQ);
            end else if (pick < 70) begin
               put_byte($urandom_range(1) ? CH_LPAR : CH_RPAR);
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 3)) begin
                  r = $urandom_range(6);
                  put_byte(r == 6 ? 8'h20 : 8'(8'h09 + r));
               end
            end else if (pick < 93) begin
               if ($urandom_range(1)) put_byte(8'($urandom_range(128, 255)));
               else put_byte(punct[$urandom_range(punct.len() - 1)]);
            end else if (pick < 98) begin
               put_byte(8'($urandom_range(1, 255)));
            end else begin
               put_byte(CH_NUL);
               repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
            end
         end
         close_text();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (text_bytes.size() != 0 || req_valid || tokens_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && tokens_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/etl_pkg.sv
rtl/etl_scan.sv
rtl/etl_serial.sv
rtl/expression_token_lexer.sv
test/expression_token_lexer_tb.sv
